/* sv/ffps_pkg.sv */
// ----------------------------------------------------------------------------
// ffps_pkg
// shared constants, codes and types of the flow-field particle stepper
// ----------------------------------------------------------------------------
package ffps_pkg;

    // default field memory depth, a power of two
    localparam int FIELD_CELLS_DEF = 4096;

    // shared divide / square-root unit sizing
    localparam int DS_DW = 34;    // dividend / radicand shift register
    localparam int DS_RW = 22;    // partial remainder
    localparam int DS_VW = 17;    // divisor
    localparam int DS_SW = 6;     // step counter

    // configuration register indexes
    localparam logic [2:0] CFG_SAMPLING  = 3'd0;
    localparam logic [2:0] CFG_INTERVAL  = 3'd1;
    localparam logic [2:0] CFG_COLUMNS   = 3'd2;
    localparam logic [2:0] CFG_WIDTH     = 3'd3;
    localparam logic [2:0] CFG_HEIGHT    = 3'd4;
    localparam logic [2:0] CFG_MAX_SPEED = 3'd5;

    // configuration reset values
    localparam logic        RST_SAMPLING  = 1'b0;
    localparam logic [6:0]  RST_INTERVAL  = 7'd8;
    localparam logic [12:0] RST_COLUMNS   = 13'd64;
    localparam logic [12:0] RST_WIDTH     = 13'd512;
    localparam logic [12:0] RST_HEIGHT    = 13'd512;
    localparam logic [15:0] RST_MAX_SPEED = 16'd256;

    // input item modes
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_PLACE = 2'd2;

    // request to the shared unit
    typedef struct packed {
        logic             start;
        logic             sqrt;
        logic [DS_SW-1:0] steps;
    } t_ds_req;

    // response from the shared unit
    typedef struct packed {
        logic             done;
        logic [DS_DW-1:0] quo;
    } t_ds_rsp;

endpackage

/* sv/ffps_ram.sv */
// ----------------------------------------------------------------------------
// ffps_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module ffps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/ffps_divsqrt.sv */
// ----------------------------------------------------------------------------
// ffps_divsqrt
// shared restoring divider and digit-by-digit square root, one bit per cycle
// ----------------------------------------------------------------------------
module ffps_divsqrt import ffps_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ds_req          i_req,
    input  logic [DS_DW-1:0] i_dvd,
    input  logic [DS_VW-1:0] i_dvr,
    output t_ds_rsp          o_rsp
);

    logic             r_busy;
    logic             r_done;
    logic             r_sqrt;
    logic [DS_SW-1:0] r_cnt;
    logic [DS_DW-1:0] r_d;
    logic [DS_RW-1:0] r_r;
    logic [DS_DW-1:0] r_q;
    logic [DS_VW-1:0] r_dvr;

    logic [DS_RW-1:0] w_sh;
    logic [DS_RW-1:0] w_trial;
    logic [DS_RW:0]   w_diff;
    logic             w_ge;

    // one compare-subtract shared by both operations
    always_comb begin
        if (r_sqrt) begin
            w_sh    = {r_r[DS_RW-3:0], r_d[DS_DW-1:DS_DW-2]};
            w_trial = {r_q[DS_RW-3:0], 2'b01};
        end else begin
            w_sh    = {r_r[DS_RW-2:0], r_d[DS_DW-1]};
            w_trial = DS_RW'(r_dvr);
        end
        w_diff = {1'b0, w_sh} - {1'b0, w_trial};
        w_ge   = ~w_diff[DS_RW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DS_SW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_sqrt <= i_req.sqrt;
            r_d    <= i_dvd;
            r_dvr  <= i_dvr;
            r_r    <= '0;
            r_q    <= '0;
        end else if (r_busy) begin
            r_d <= r_sqrt ? {r_d[DS_DW-3:0], 2'b00} : {r_d[DS_DW-2:0], 1'b0};
            r_r <= w_ge ? w_diff[DS_RW-1:0] : w_sh;
            r_q <= {r_q[DS_DW-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;

endmodule

/* sv/flow_field_particle_step.sv */
// ----------------------------------------------------------------------------
// flow_field_particle_step
// one particle stepped through a stored flow field with a speed limit
// ----------------------------------------------------------------------------
// input channel (i_in_valid / o_in_stall): load, place and tick transactions;
//   loads write one field cell, places set the particle, neither gives a result
// output channel (o_out_valid / i_out_stall): one transaction per tick with
//   the drawn segment, the cell used and a stopped flag
// tick steps: per-pixel mode computes the cell, reads the field and updates the
//   velocity; coarse mode first divides both coordinates by the interval for
//   the cell, and when the speed limit engages a square root and two component
//   divisions follow, all on the shared one-bit-per-cycle divide / sqrt unit
// o_in_stall stays high while a tick is in work, so no new item is taken
//   until the tick is through; loads and places are taken back to back
// a finished result waits in the output register while i_out_stall is high;
//   the next item is still taken, and a following tick holds in its final step
// configuration writes (i_cfg_valid / o_cfg_ready) are always taken and must
//   only be issued while the block is idle
// reset (synchronous, active low) clears the particle and the registers;
//   field cells are undefined until loaded, FIELD_CELLS is a power of two
// ----------------------------------------------------------------------------
module flow_field_particle_step import ffps_pkg::*; #(
    parameter int FIELD_CELLS = FIELD_CELLS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input item channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_mode,
    input  logic [11:0]        i_cell_index,
    input  logic signed [15:0] i_force_x,
    input  logic signed [15:0] i_force_y,
    input  logic [19:0]        i_place_x,
    input  logic [19:0]        i_place_y,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [20:0] o_from_x,
    output logic signed [20:0] o_from_y,
    output logic signed [20:0] o_to_x,
    output logic signed [20:0] o_to_y,
    output logic [11:0]        o_looked_up_cell,
    output logic               o_stopped,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    localparam int AW = $clog2(FIELD_CELLS);
    localparam int CW = (AW > 12) ? AW : 12;

    // sequencer states
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CX_GO  = 5'd1;
    localparam logic [4:0] S_CX_WT  = 5'd2;
    localparam logic [4:0] S_CY_GO  = 5'd3;
    localparam logic [4:0] S_CY_WT  = 5'd4;
    localparam logic [4:0] S_CMUL   = 5'd5;
    localparam logic [4:0] S_CADD   = 5'd6;
    localparam logic [4:0] S_RD     = 5'd7;
    localparam logic [4:0] S_RDW    = 5'd8;
    localparam logic [4:0] S_VX2    = 5'd9;
    localparam logic [4:0] S_VY2    = 5'd10;
    localparam logic [4:0] S_MS2    = 5'd11;
    localparam logic [4:0] S_CMP    = 5'd12;
    localparam logic [4:0] S_SQ_GO  = 5'd13;
    localparam logic [4:0] S_SQ_WT  = 5'd14;
    localparam logic [4:0] S_PX     = 5'd15;
    localparam logic [4:0] S_DX_GO  = 5'd16;
    localparam logic [4:0] S_DX_WT  = 5'd17;
    localparam logic [4:0] S_PY     = 5'd18;
    localparam logic [4:0] S_DY_GO  = 5'd19;
    localparam logic [4:0] S_DY_WT  = 5'd20;
    localparam logic [4:0] S_MOVE   = 5'd21;

    // configuration registers
    logic        r_sampling;
    logic [6:0]  r_interval;
    logic [12:0] r_columns;
    logic [12:0] r_width;
    logic [12:0] r_height;
    logic [15:0] r_max_speed;

    // particle state; the previous position always equals the position
    // between items, so only the position is kept
    logic signed [20:0] r_px;
    logic signed [20:0] r_py;
    logic signed [16:0] r_vx;
    logic signed [16:0] r_vy;

    // sequencer and work registers
    logic [4:0]  r_state;
    logic [4:0]  n_state;
    logic [11:0] r_cx;
    logic [11:0] r_cy;
    logic [AW-1:0] r_cell;
    logic [31:0] r_prod;
    logic [32:0] r_m;
    logic [16:0] r_mag;

    // output register
    logic               r_ov;
    logic signed [20:0] r_from_x;
    logic signed [20:0] r_from_y;
    logic signed [20:0] r_to_x;
    logic signed [20:0] r_to_y;
    logic [11:0]        r_lcell;
    logic               r_stopped;

    logic w_in_acc;
    logic w_out_free;

    assign w_in_acc   = i_in_valid & ~o_in_stall;
    assign w_out_free = ~r_ov | ~i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------------
    // field memory: x in the low half, y in the high half of a word
    // ------------------------------------------------------------------------
    logic [CW-1:0] w_load_idx;
    logic [31:0]   w_word;
    logic          w_we;

    assign w_load_idx = CW'(i_cell_index);
    assign w_we       = w_in_acc & (i_mode == MODE_LOAD);

    ffps_ram #(
        .WIDTH (32),
        .DEPTH (FIELD_CELLS)
    ) u_field (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_load_idx[AW-1:0]),
        .i_wdata ({i_force_y, i_force_x}),
        .i_raddr (r_cell),
        .o_rdata (w_word)
    );

    // ------------------------------------------------------------------------
    // shared divide / square-root unit
    // ------------------------------------------------------------------------
    t_ds_req          w_req;
    t_ds_rsp          w_rsp;
    logic [DS_DW-1:0] w_dvd;
    logic [DS_VW-1:0] w_dvr;
    logic [6:0]       w_iv;

    // zero interval acts as one
    assign w_iv = (r_interval == 7'd0) ? 7'd1 : r_interval;

    always_comb begin
        w_req.start = 1'b0;
        w_req.sqrt  = 1'b0;
        w_req.steps = DS_SW'(12);
        w_dvd       = '0;
        w_dvr       = DS_VW'(w_iv);
        unique case (r_state)
            S_CX_GO: begin
                w_req.start = 1'b1;
                w_dvd       = {r_px[19:8], 22'd0};
            end
            S_CY_GO: begin
                w_req.start = 1'b1;
                w_dvd       = {r_py[19:8], 22'd0};
            end
            S_SQ_GO: begin
                w_req.start = 1'b1;
                w_req.sqrt  = 1'b1;
                w_req.steps = DS_SW'(17);
                w_dvd       = {1'b0, r_m};
            end
            S_DX_GO, S_DY_GO: begin
                w_req.start = 1'b1;
                w_req.steps = DS_SW'(32);
                w_dvd       = {r_prod, 2'b00};
                w_dvr       = r_mag;
            end
            default: begin
            end
        endcase
    end

    ffps_divsqrt u_ds (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_dvd   (w_dvd),
        .i_dvr   (w_dvr),
        .o_rsp   (w_rsp)
    );

    // ------------------------------------------------------------------------
    // shared multiplier, product registered
    // ------------------------------------------------------------------------
    logic [15:0] w_abs_vx;
    logic [15:0] w_abs_vy;
    logic [15:0] w_mul_a;
    logic [15:0] w_mul_b;

    assign w_abs_vx = r_vx[16] ? 16'(-r_vx) : r_vx[15:0];
    assign w_abs_vy = r_vy[16] ? 16'(-r_vy) : r_vy[15:0];

    always_comb begin
        unique case (r_state)
            S_CMUL: begin
                w_mul_a = 16'(r_cy);
                w_mul_b = r_sampling ? 16'(r_width) : 16'(r_columns);
            end
            S_VX2: begin
                w_mul_a = w_abs_vx;
                w_mul_b = w_abs_vx;
            end
            S_VY2: begin
                w_mul_a = w_abs_vy;
                w_mul_b = w_abs_vy;
            end
            S_MS2: begin
                w_mul_a = r_max_speed;
                w_mul_b = r_max_speed;
            end
            S_PX: begin
                w_mul_a = w_abs_vx;
                w_mul_b = r_max_speed;
            end
            default: begin
                w_mul_a = w_abs_vy;
                w_mul_b = r_max_speed;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // velocity update: force rounded to 8 fraction bits, add, saturate
    // ------------------------------------------------------------------------
    logic signed [16:0] w_rfx;
    logic signed [16:0] w_rfy;
    logic signed [16:0] w_vxb;
    logic signed [16:0] w_vyb;
    logic signed [17:0] w_sx;
    logic signed [17:0] w_sy;
    logic signed [16:0] w_satx;
    logic signed [16:0] w_saty;
    logic               w_zero_stop;

    assign w_rfx = {w_word[15], w_word[15:0]} + 17'sd32;
    assign w_rfy = {w_word[31], w_word[31:16]} + 17'sd32;

    // per-pixel mode: an empty cell stops the particle first
    assign w_zero_stop = r_sampling & (w_word == 32'd0);
    assign w_vxb = w_zero_stop ? 17'sd0 : r_vx;
    assign w_vyb = w_zero_stop ? 17'sd0 : r_vy;

    assign w_sx = {w_vxb[16], w_vxb} + {{7{w_rfx[16]}}, w_rfx[16:6]};
    assign w_sy = {w_vyb[16], w_vyb} + {{7{w_rfy[16]}}, w_rfy[16:6]};

    always_comb begin
        if (w_sx > 18'sd65535) begin
            w_satx = 17'sd65535;
        end else if (w_sx < -18'sd65535) begin
            w_satx = -17'sd65535;
        end else begin
            w_satx = w_sx[16:0];
        end
        if (w_sy > 18'sd65535) begin
            w_saty = 17'sd65535;
        end else if (w_sy < -18'sd65535) begin
            w_saty = -17'sd65535;
        end else begin
            w_saty = w_sy[16:0];
        end
    end

    // scaled component, sign restored after the magnitude division
    logic signed [16:0] w_qs;
    logic               w_qneg;

    assign w_qneg = (r_state == S_DX_WT) ? r_vx[16] : r_vy[16];
    assign w_qs   = w_qneg ? -$signed({1'b0, w_rsp.quo[15:0]})
                           : $signed({1'b0, w_rsp.quo[15:0]});

    // ------------------------------------------------------------------------
    // move and wrap at the frame edges
    // ------------------------------------------------------------------------
    logic [12:0]        w_w;
    logic [12:0]        w_h;
    logic signed [21:0] w_npx;
    logic signed [21:0] w_npy;
    logic signed [21:0] w_wlim;
    logic signed [21:0] w_hlim;
    logic signed [20:0] w_x1;
    logic signed [20:0] w_y1;
    logic               w_wrap_x;
    logic               w_wrap_y;
    logic signed [20:0] w_from_x;
    logic signed [20:0] w_from_y;

    // zero frame size acts as one, oversized as 4096
    always_comb begin
        if (r_width == 13'd0) begin
            w_w = 13'd1;
        end else if (r_width > 13'd4096) begin
            w_w = 13'd4096;
        end else begin
            w_w = r_width;
        end
        if (r_height == 13'd0) begin
            w_h = 13'd1;
        end else if (r_height > 13'd4096) begin
            w_h = 13'd4096;
        end else begin
            w_h = r_height;
        end
    end

    assign w_npx  = {r_px[20], r_px} + {{5{r_vx[16]}}, r_vx};
    assign w_npy  = {r_py[20], r_py} + {{5{r_vy[16]}}, r_vy};
    assign w_wlim = $signed({1'b0, w_w, 8'd0});
    assign w_hlim = $signed({1'b0, w_h, 8'd0});

    always_comb begin
        w_wrap_x = 1'b1;
        if (w_npx >= w_wlim) begin
            w_x1 = 21'sd0;
        end else if (w_npx < 22'sd0) begin
            w_x1 = $signed({13'(w_w - 13'd1), 8'd0});
        end else begin
            w_x1     = w_npx[20:0];
            w_wrap_x = 1'b0;
        end
        w_wrap_y = 1'b1;
        if (w_npy >= w_hlim) begin
            w_y1 = 21'sd0;
        end else if (w_npy < 22'sd0) begin
            w_y1 = $signed({13'(w_h - 13'd1), 8'd0});
        end else begin
            w_y1     = w_npy[20:0];
            w_wrap_y = 1'b0;
        end
        // the last wrap restarts the segment at the point reached so far
        if (w_wrap_y) begin
            w_from_x = w_x1;
            w_from_y = w_y1;
        end else if (w_wrap_x) begin
            w_from_x = w_x1;
            w_from_y = w_npy[20:0];
        end else begin
            w_from_x = r_px;
            w_from_y = r_py;
        end
    end

    logic [CW-1:0] w_cell_ext;
    assign w_cell_ext = CW'(r_cell);

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_mode == MODE_TICK) begin
                    n_state = r_sampling ? S_CMUL : S_CX_GO;
                end
            end
            S_CX_GO: n_state = S_CX_WT;
            S_CX_WT: if (w_rsp.done) n_state = S_CY_GO;
            S_CY_GO: n_state = S_CY_WT;
            S_CY_WT: if (w_rsp.done) n_state = S_CMUL;
            S_CMUL:  n_state = S_CADD;
            S_CADD:  n_state = S_RD;
            S_RD:    n_state = S_RDW;
            S_RDW:   n_state = S_VX2;
            S_VX2:   n_state = S_VY2;
            S_VY2:   n_state = S_MS2;
            S_MS2:   n_state = S_CMP;
            S_CMP:   n_state = (r_m > {1'b0, r_prod}) ? S_SQ_GO : S_MOVE;
            S_SQ_GO: n_state = S_SQ_WT;
            S_SQ_WT: if (w_rsp.done) n_state = S_PX;
            S_PX:    n_state = S_DX_GO;
            S_DX_GO: n_state = S_DX_WT;
            S_DX_WT: if (w_rsp.done) n_state = S_PY;
            S_PY:    n_state = S_DY_GO;
            S_DY_GO: n_state = S_DY_WT;
            S_DY_WT: if (w_rsp.done) n_state = S_MOVE;
            S_MOVE:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state, configuration and particle state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ov        <= 1'b0;
            r_sampling  <= RST_SAMPLING;
            r_interval  <= RST_INTERVAL;
            r_columns   <= RST_COLUMNS;
            r_width     <= RST_WIDTH;
            r_height    <= RST_HEIGHT;
            r_max_speed <= RST_MAX_SPEED;
            r_px        <= '0;
            r_py        <= '0;
            r_vx        <= '0;
            r_vy        <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_SAMPLING:  r_sampling  <= i_cfg_data[0];
                    CFG_INTERVAL:  r_interval  <= i_cfg_data[6:0];
                    CFG_COLUMNS:   r_columns   <= i_cfg_data[12:0];
                    CFG_WIDTH:     r_width     <= i_cfg_data[12:0];
                    CFG_HEIGHT:    r_height    <= i_cfg_data[12:0];
                    CFG_MAX_SPEED: r_max_speed <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (w_in_acc && i_mode == MODE_PLACE) begin
                r_px <= $signed({1'b0, i_place_x});
                r_py <= $signed({1'b0, i_place_y});
            end

            if (r_state == S_RDW) begin
                r_vx <= w_satx;
                r_vy <= w_saty;
            end
            if (r_state == S_DX_WT && w_rsp.done) begin
                r_vx <= w_qs;
            end
            if (r_state == S_DY_WT && w_rsp.done) begin
                r_vy <= w_qs;
            end

            if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            if (r_state == S_MOVE && w_out_free) begin
                r_ov <= 1'b1;
                r_px <= w_x1;
                r_py <= w_y1;
            end
        end
    end

    // work and output payload registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        if (r_state == S_IDLE) begin
            r_cx <= r_px[19:8];
            r_cy <= r_py[19:8];
        end
        if (r_state == S_CX_WT && w_rsp.done) begin
            r_cx <= w_rsp.quo[11:0];
        end
        if (r_state == S_CY_WT && w_rsp.done) begin
            r_cy <= w_rsp.quo[11:0];
        end
        if (r_state == S_CADD) begin
            r_cell <= AW'(32'(r_cx) + r_prod);
        end
        if (r_state == S_VY2) begin
            r_m <= {1'b0, r_prod};
        end
        if (r_state == S_MS2) begin
            r_m <= r_m + {1'b0, r_prod};
        end
        if (r_state == S_SQ_WT && w_rsp.done) begin
            r_mag <= w_rsp.quo[16:0];
        end
        if (r_state == S_MOVE && w_out_free) begin
            r_from_x  <= w_from_x;
            r_from_y  <= w_from_y;
            r_to_x    <= w_x1;
            r_to_y    <= w_y1;
            r_lcell   <= w_cell_ext[11:0];
            r_stopped <= (r_vx == 17'sd0) && (r_vy == 17'sd0);
        end
    end

    assign o_out_valid      = r_ov;
    assign o_from_x         = r_from_x;
    assign o_from_y         = r_from_y;
    assign o_to_x           = r_to_x;
    assign o_to_y           = r_to_y;
    assign o_looked_up_cell = r_lcell;
    assign o_stopped        = r_stopped;

endmodule

/* test/flow_field_particle_step_tb.sv */
// ----------------------------------------------------------------------------
// flow_field_particle_step_tb
// self-checking bench: field loads, placements and ticks against a particle
// predictor, swept through sampling modes, frame sizes and speed limits
// ----------------------------------------------------------------------------
module flow_field_particle_step_tb;
    import ffps_pkg::*;

    localparam int  CELLS      = FIELD_CELLS_DEF;
    localparam int  SETTLE     = 200;      // longer than the slowest tick
    localparam int  LIMIT      = 2000000;  // cycle cap for the whole run
    localparam int  PHASE_SIZE = 55;

    // unused mode and register indexes past the list
    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam logic [2:0] CFG_SPARE_A = 3'd6;
    localparam logic [2:0] CFG_SPARE_B = 3'd7;

    // one input transaction
    typedef struct packed {
        logic [1:0]         mode;
        logic [11:0]        cell_no;
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        logic [19:0]        plx;
        logic [19:0]        ply;
    } item_t;

    // one drawn segment
    typedef struct packed {
        logic signed [20:0] from_x;
        logic signed [20:0] from_y;
        logic signed [20:0] to_x;
        logic signed [20:0] to_y;
        logic [11:0]        cell_no;
        logic               stopped;
    } segment_t;

    // particle, field and register copy
    typedef struct {
        longint      px, py, qx, qy, vx, vy;
        bit          per_pixel;
        longint      interval, columns, fw, fh, speed_cap;
        logic [31:0] cells [CELLS];
        bit          loaded [CELLS];
    } particle_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_mode = MODE_LOAD;
    logic [11:0]        i_cell_index = '0;
    logic signed [15:0] i_force_x = '0;
    logic signed [15:0] i_force_y = '0;
    logic [19:0]        i_place_x = '0;
    logic [19:0]        i_place_y = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [20:0] o_from_x, o_from_y, o_to_x, o_to_y;
    logic [11:0]        o_looked_up_cell;
    logic               o_stopped;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;

    flow_field_particle_step dut (.*);

    // planning copy (stimulus generation) and checking copy (on acceptance)
    particle_t plan_st;
    particle_t track_st;

    item_t    item_q [$];
    segment_t segment_q [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_asked = 0;
    int hold_served = 0;
    int errors = 0;
    int ticks_seen = 0;
    int loads_sent = 0;
    int places_sent = 0;
    int cycles = 0;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic void reset_particle(ref particle_t s);
        s.px = 0; s.py = 0; s.qx = 0; s.qy = 0; s.vx = 0; s.vy = 0;
        s.per_pixel = RST_SAMPLING;
        s.interval  = longint'(RST_INTERVAL);
        s.columns   = longint'(RST_COLUMNS);
        s.fw        = longint'(RST_WIDTH);
        s.fh        = longint'(RST_HEIGHT);
        s.speed_cap = longint'(RST_MAX_SPEED);
        foreach (s.loaded[i]) s.loaded[i] = 1'b0;
    endfunction

    function automatic void apply_reg(ref particle_t s, input logic [2:0] idx,
                                      input logic [15:0] val);
        case (idx)
            CFG_SAMPLING:  s.per_pixel = val[0];
            CFG_INTERVAL:  s.interval  = longint'(val[6:0]);
            CFG_COLUMNS:   s.columns   = longint'(val[12:0]);
            CFG_WIDTH:     s.fw        = longint'(val[12:0]);
            CFG_HEIGHT:    s.fh        = longint'(val[12:0]);
            CFG_MAX_SPEED: s.speed_cap = longint'(val);
            default: ;
        endcase
    endfunction

    // frame size clamped to 1..4096
    function automatic longint frame_dim(longint v);
        if (v == 0) return 1;
        return (v > 4096) ? 4096 : v;
    endfunction

    // cell under the particle; positions are never negative between ticks
    function automatic logic [11:0] cell_under(ref particle_t s);
        longint iv, c;
        if (s.per_pixel) begin
            c = (s.px >>> 8) + (s.py >>> 8) * s.fw;
        end else begin
            iv = (s.interval == 0) ? 1 : s.interval;
            c = s.px / (iv * 256) + (s.py / (iv * 256)) * s.columns;
        end
        return c[11:0];
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r, b;
        r = 0;
        b = longint'(1) <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic void step_particle(ref particle_t s, input item_t it,
                                          output bit has, output segment_t r);
        logic [11:0] c;
        logic [31:0] word;
        longint      fx, fy, mag, w, h;
        has = 1'b0;
        r = '0;
        case (it.mode)
            MODE_LOAD: begin
                s.cells[it.cell_no]  = {it.fy, it.fx};
                s.loaded[it.cell_no] = 1'b1;
            end
            MODE_PLACE: begin
                s.px = longint'(it.plx); s.qx = longint'(it.plx);
                s.py = longint'(it.ply); s.qy = longint'(it.ply);
            end
            MODE_TICK: begin
                c = cell_under(s);
                word = s.cells[c];
                if (s.per_pixel && word == 0) begin
                    s.vx = 0; s.vy = 0;
                end
                // 14 to 8 fraction bits, round half up
                fx = (longint'($signed(word[15:0])) + 32) >>> 6;
                fy = (longint'($signed(word[31:16])) + 32) >>> 6;
                s.vx += fx;
                s.vy += fy;
                if (s.vx > 65535) s.vx = 65535;
                if (s.vx < -65535) s.vx = -65535;
                if (s.vy > 65535) s.vy = 65535;
                if (s.vy < -65535) s.vy = -65535;
                // speed limit, truncating toward zero
                if (s.vx * s.vx + s.vy * s.vy > s.speed_cap * s.speed_cap) begin
                    mag = int_sqrt(s.vx * s.vx + s.vy * s.vy);
                    s.vx = (s.vx * s.speed_cap) / mag;
                    s.vy = (s.vy * s.speed_cap) / mag;
                end
                w = frame_dim(s.fw);
                h = frame_dim(s.fh);
                s.px += s.vx;
                s.py += s.vy;
                // each wrap restarts the segment at the wrapped point
                if (s.px >= w * 256) begin
                    s.px = 0; s.qx = s.px; s.qy = s.py;
                end
                if (s.px < 0) begin
                    s.px = (w - 1) * 256; s.qx = s.px; s.qy = s.py;
                end
                if (s.py >= h * 256) begin
                    s.py = 0; s.qx = s.px; s.qy = s.py;
                end
                if (s.py < 0) begin
                    s.py = (h - 1) * 256; s.qx = s.px; s.qy = s.py;
                end
                r.from_x  = s.qx[20:0];
                r.from_y  = s.qy[20:0];
                r.to_x    = s.px[20:0];
                r.to_y    = s.py[20:0];
                r.cell_no = c;
                r.stopped = (s.vx == 0 && s.vy == 0);
                s.qx = s.px;
                s.qy = s.py;
                has = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // clock and cycle cap
    // ------------------------------------------------------------------------
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // driver: offers queued items, predicts each accepted transaction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        bit       has;
        segment_t seg;
        item_t    nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) begin
                step_particle(track_st, {i_mode, i_cell_index, i_force_x, i_force_y,
                                         i_place_x, i_place_y}, has, seg);
                if (has) segment_q = {segment_q, seg};
            end
            // sender gaps fall at random
            if (item_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = item_q.pop_front();
                i_mode       <= nxt.mode;
                i_cell_index <= nxt.cell_no;
                i_force_x    <= nxt.fx;
                i_force_y    <= nxt.fy;
                i_place_x    <= nxt.plx;
                i_place_y    <= nxt.ply;
                i_in_valid   <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks result transactions and drives the receiver stall
    // ------------------------------------------------------------------------
    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    int hold_left = 0;

    always @(posedge i_clk) begin
        segment_t want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                ticks_seen++;
                if (segment_q.size() == 0) begin
                    $error("segment transaction with nothing expected");
                    errors++;
                end else begin
                    want = segment_q.pop_front();
                    check_field("from_x", want.from_x, o_from_x);
                    check_field("from_y", want.from_y, o_from_y);
                    check_field("to_x", want.to_x, o_to_x);
                    check_field("to_y", want.to_y, o_to_y);
                    check_field("looked_up_cell", want.cell_no, o_looked_up_cell);
                    check_field("stopped", want.stopped, o_stopped);
                end
            end
            // a long hold-off forces the block to back up its input
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_out_stall <= 1'b1;
            end else if (hold_served < hold_asked) begin
                hold_served <= hold_served + 1;
                hold_left <= 400;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic push_item(item_t it);
        bit       has;
        segment_t seg;
        item_q = {item_q, it};
        step_particle(plan_st, it, has, seg);
        if (it.mode == MODE_LOAD) loads_sent++;
        if (it.mode == MODE_PLACE) places_sent++;
    endtask

    function automatic logic [15:0] pick_force();
        if ($urandom_range(9) == 0) return 16'($urandom());
        return 16'($signed($urandom_range(32768)) - 16384);
    endfunction

    task automatic push_load(logic [11:0] c, logic [15:0] fx, logic [15:0] fy);
        push_item({MODE_LOAD, c, fx, fy, 20'($urandom()), 20'($urandom())});
    endtask

    task automatic push_place(logic [19:0] x, logic [19:0] y);
        push_item({MODE_PLACE, 12'($urandom()), 16'($urandom()), 16'($urandom()), x, y});
    endtask

    // a tick never reads an unloaded cell: load it first when needed
    task automatic push_tick();
        logic [11:0] c;
        c = cell_under(plan_st);
        if (!plan_st.loaded[c]) push_load(c, pick_force(), pick_force());
        push_item({MODE_TICK, 12'($urandom()), 16'($urandom()), 16'($urandom()),
                   20'($urandom()), 20'($urandom())});
    endtask

    task automatic random_items(int n);
        int    pick;
        longint w, h;
        repeat (n) begin
            pick = $urandom_range(99);
            w = frame_dim(plan_st.fw);
            h = frame_dim(plan_st.fh);
            if (pick < 48) begin
                push_tick();
            end else if (pick < 68) begin
                push_load(12'($urandom()), pick_force(), pick_force());
            end else if (pick < 78) begin
                if ($urandom_range(3) == 0)
                    push_place(20'($urandom()), 20'($urandom()));
                else
                    push_place(20'($urandom_range(32'(w * 256 - 1))),
                               20'($urandom_range(32'(h * 256 - 1))));
            end else if (pick < 82) begin
                // unused mode, ignored by the block
                push_item({MODE_SPARE, 12'($urandom()), 16'($urandom()), 16'($urandom()),
                           20'($urandom()), 20'($urandom())});
            end else if (pick < 92) begin
                // rewrite the cell under the particle, zero vectors now and then
                if ($urandom_range(2) == 0)
                    push_load(cell_under(plan_st), '0, '0);
                else
                    push_load(cell_under(plan_st), pick_force(), pick_force());
                push_tick();
            end else begin
                repeat (4) push_tick();
            end
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        apply_reg(plan_st, idx, val);
        apply_reg(track_st, idx, val);
    endtask

    // sender pauses until every segment has come, then lets the block settle
    task automatic drain();
        while (item_q.size() > 0 || i_in_valid || segment_q.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic run_phase(bit pp, int iv, int cols, int fw, int fh, int cap,
                             int send_pct, int recv_pct);
        drain();
        write_reg(CFG_SAMPLING, 16'(pp));
        write_reg(CFG_INTERVAL, 16'(iv));
        write_reg(CFG_COLUMNS, 16'(cols));
        write_reg(CFG_WIDTH, 16'(fw));
        write_reg(CFG_HEIGHT, 16'(fh));
        write_reg(CFG_MAX_SPEED, 16'(cap));
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        random_items(PHASE_SIZE);
    endtask

    initial begin
        reset_particle(plan_st);
        reset_particle(track_st);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, field extremes, wraps on both sides
        send_idle_pct  = 36;
        recv_stall_pct = 48;
        push_load(12'hFFF, -16'sd16384, 16'sd16384);
        push_load(12'h000, 16'sh7FFF, 16'sh8000);
        push_tick();
        push_place(20'hFFFFF, 20'hFFFFF);
        push_tick();
        push_place('0, '0);
        push_load(12'h000, -16'sd16384, -16'sd16384);
        push_tick();
        push_tick();
        push_item({MODE_SPARE, 12'hFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 20'hFFFFF});
        push_load(12'hFFF, '0, '0);
        push_place(20'd1000, 20'd2000);
        push_tick();
        push_load(12'h555, 16'sd16384, -16'sd16384);
        drain();

        // per-pixel, zero vectors stop the particle
        write_reg(CFG_SAMPLING, 16'd1);
        push_place(20'd256, 20'd256);
        push_load(cell_under(plan_st), 16'sd16384, 16'sd0);
        push_tick();
        push_load(cell_under(plan_st), '0, '0);
        push_tick();
        drain();
        // indexes past the register list are ignored
        write_reg(CFG_SPARE_A, 16'hFFFF);
        write_reg(CFG_SPARE_B, 16'h1234);

        random_items(PHASE_SIZE);
        run_phase(1, 8, 64, 64, 64, 65535, 36, 48);
        run_phase(0, 1, 4096, 4096, 4096, 1, 36, 48);
        hold_asked++;
        random_items(20);
        run_phase(0, 64, 1, 1, 1, 0, 48, 36);
        // zero frame width acts as one, oversized height as 4096
        run_phase(1, 127, 8191, 0, 8191, 300, 48, 36);
        run_phase(0, 0, 0, 100, 37, 512, 48, 36);
        run_phase(1, 5, 13, 4096, 4096, 65535, 0, 0);
        run_phase(0, $urandom_range(1, 64), $urandom_range(1, 4096), $urandom_range(1, 4096),
                  $urandom_range(1, 4096), $urandom_range(1, 65535), 0, 0);
        drain();

        $display("covered %0d ticks, %0d field loads, %0d placements over nine settings",
                 ticks_seen, loads_sent, places_sent);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", errors);
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/ffps_pkg.sv
sv/ffps_ram.sv
sv/ffps_divsqrt.sv
sv/flow_field_particle_step.sv
test/flow_field_particle_step_tb.sv
